// ===== hdl/hcbe_pkg.sv =====
// hcbe_pkg: shared types, constants and alphabet functions for the hill cipher block encryptor
// no dependencies; imported by every module of the block
package hcbe_pkg;

    localparam int MAX_ORDER_DEF = 7;
    localparam int ORDER_W       = 3;
    localparam int SYM_W         = 6;
    localparam int CHAR_W        = 8;
    localparam int KEY_W         = 42;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 42;
    localparam int QUEUE_DEPTH   = 2;

    // arithmetic widths (sized for the largest order of seven)
    localparam int PROD_W        = 2 * SYM_W;
    localparam int SUM_W         = 15;
    localparam int QUO_W         = 9;
    localparam int RECIP_W       = 13;
    localparam int MULQ_W        = SUM_W + RECIP_W;
    localparam int REM_W         = 7;

    localparam logic [SUM_W-1:0]   ALPHA_SIZE  = 15'd53;
    // floor(2^18 / 53); quotient estimate is exact or one low for sums below 2^15
    localparam logic [RECIP_W-1:0] RECIP       = 13'd4946;
    localparam int                 RECIP_SHIFT = 18;

    localparam logic [SYM_W-1:0] PAD_INDEX   = 6'd50;
    localparam logic [SYM_W-1:0] SPACE_INDEX = 6'd26;
    localparam logic [SYM_W-1:0] LOWER_BASE  = 6'd27;
    localparam logic [SYM_W-1:0] N_INDEX     = 6'd13;

    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_N_TILDE = 8'hD1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLOCK_SIZE = 3'd0,
        REG_KEY_ROW0   = 3'd1,
        REG_KEY_ROW1   = 3'd2,
        REG_KEY_ROW2   = 3'd3,
        REG_KEY_ROW3   = 3'd4,
        REG_KEY_ROW4   = 3'd5,
        REG_KEY_ROW5   = 3'd6,
        REG_KEY_ROW6   = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [SYM_W-1:0] idx;
        logic             unknown;
    } sym_t;

    // per-block control that travels with a buffered block
    typedef struct packed {
        logic [ORDER_W-1:0] order;
        logic               eom;
        logic               unk;
    } job_ctl_t;

    function automatic sym_t char_to_sym(logic [CHAR_W-1:0] c);
        sym_t s;
        s.idx     = '0;
        s.unknown = 1'b0;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
        begin
            s.idx = SYM_W'(c - CH_UPPER_A);
        end
        else if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
        begin
            s.idx = SYM_W'(c - CH_LOWER_A) + LOWER_BASE;
        end
        else if (c == CH_SPACE)
        begin
            s.idx = SPACE_INDEX;
        end
        else if (c == CH_N_TILDE)
        begin
            s.idx = N_INDEX;
        end
        else
        begin
            s.unknown = 1'b1;
        end
        return s;
    endfunction

    function automatic logic [CHAR_W-1:0] index_to_char(logic [SYM_W-1:0] r);
        logic [CHAR_W-1:0] c;
        if (r < SPACE_INDEX)
        begin
            c = CH_UPPER_A + CHAR_W'(r);
        end
        else if (r == SPACE_INDEX)
        begin
            c = CH_SPACE;
        end
        else
        begin
            c = CH_LOWER_A + CHAR_W'(r - LOWER_BASE);
        end
        return c;
    endfunction

endpackage

// ===== hdl/hcbe_front.sv =====
// hcbe_front: maps characters to alphabet indices and gathers them into padded blocks
// depends on hcbe_pkg
module hcbe_front #(
    parameter int MAX_ORDER = hcbe_pkg::MAX_ORDER_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  char_valid,
    output logic                                  char_ready,
    input  logic [hcbe_pkg::CHAR_W-1:0]           char_code,
    input  logic                                  end_of_message,
    input  logic [hcbe_pkg::ORDER_W-1:0]          order,
    output logic                                  job_valid,
    input  logic                                  job_ready,
    output logic [MAX_ORDER*hcbe_pkg::SYM_W-1:0]  job_vec,
    output hcbe_pkg::job_ctl_t                    job_ctl
);
    import hcbe_pkg::*;

    logic [ORDER_W-1:0] fill_reg, fill_next;
    logic               unk_reg, unk_next;
    logic [SYM_W-1:0]   sym_reg [MAX_ORDER];
    sym_t               sym;
    logic [ORDER_W:0]   fill_inc;
    logic               close;
    logic               accept;

    assign char_ready = job_ready;
    assign accept     = char_valid && char_ready;

    always_comb
    begin
        sym       = char_to_sym(char_code);
        fill_inc  = {1'b0, fill_reg} + (ORDER_W+1)'(1);
        close     = (fill_inc >= {1'b0, order}) || end_of_message;
        job_valid = char_valid && close;
        for (int k = 0; k < MAX_ORDER; k++)
        begin
            // held chars below the fill point, current char at it, padding past it
            if (ORDER_W'(k) == fill_reg)
            begin
                job_vec[k*SYM_W +: SYM_W] = sym.idx;
            end
            else if (ORDER_W'(k) < fill_reg)
            begin
                job_vec[k*SYM_W +: SYM_W] = sym_reg[k];
            end
            else
            begin
                job_vec[k*SYM_W +: SYM_W] = PAD_INDEX;
            end
        end
        job_ctl.order = order;
        job_ctl.eom   = end_of_message;
        job_ctl.unk   = unk_reg || sym.unknown;

        fill_next = fill_reg;
        unk_next  = unk_reg;
        if (accept)
        begin
            if (close)
            begin
                fill_next = '0;
                unk_next  = 1'b0;
            end
            else
            begin
                fill_next = fill_inc[ORDER_W-1:0];
                unk_next  = unk_reg || sym.unknown;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            unk_reg  <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            unk_reg  <= unk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_ORDER; k++)
        begin
            if (accept && !close && ORDER_W'(k) == fill_reg)
            begin
                sym_reg[k] <= sym.idx;
            end
        end
    end

endmodule

// ===== hdl/hcbe_queue.sv =====
// hcbe_queue: short register queue of complete blocks between front and back
// depends on hcbe_pkg
module hcbe_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = hcbe_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data
);
    import hcbe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_data   = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/hcbe_back.sv =====
// hcbe_back: row sequencer and four-stage product, sum and mod-53 pipeline
// depends on hcbe_pkg
module hcbe_back #(
    parameter int MAX_ORDER = hcbe_pkg::MAX_ORDER_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  job_valid,
    output logic                                  job_pop,
    input  logic [MAX_ORDER*hcbe_pkg::SYM_W-1:0]  job_vec,
    input  hcbe_pkg::job_ctl_t                    job_ctl,
    input  logic [hcbe_pkg::KEY_W-1:0]            key_rows [MAX_ORDER],
    output logic                                  cipher_valid,
    input  logic                                  cipher_ready,
    output logic [hcbe_pkg::CHAR_W-1:0]           out_char,
    output logic                                  last_of_block,
    output logic                                  message_done,
    output logic                                  unknown_seen
);
    import hcbe_pkg::*;

    localparam int RIDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

    typedef struct packed {
        logic last;
        logic done;
        logic unk;
    } stage_ctl_t;

    logic               adv, issue, row_last;
    logic [ORDER_W-1:0] row_reg;
    logic [KEY_W-1:0]   key_row;
    stage_ctl_t         ctl0;

    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    stage_ctl_t         ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg;
    logic [PROD_W-1:0]  prod_reg [MAX_ORDER];
    logic [SUM_W-1:0]   sum2_reg, sum3_reg, sum_next;
    logic [QUO_W-1:0]   quo_reg;
    logic [MULQ_W-1:0]  mulq;
    logic [SUM_W-1:0]   qm;
    logic [REM_W-1:0]   rem, rem_fix;
    logic [CHAR_W-1:0]  char_reg;

    // whole pipeline moves together; it holds only while a result waits
    assign adv      = !v4_reg || cipher_ready;
    assign issue    = adv && job_valid;
    assign row_last = (row_reg == job_ctl.order - ORDER_W'(1));
    assign job_pop  = issue && row_last;
    assign key_row  = key_rows[row_reg[RIDX_W-1:0]];

    always_comb
    begin
        ctl0.last = row_last;
        ctl0.done = row_last && job_ctl.eom;
        ctl0.unk  = job_ctl.unk;

        sum_next = '0;
        for (int k = 0; k < MAX_ORDER; k++)
        begin
            sum_next = sum_next + SUM_W'(prod_reg[k]);
        end

        // quotient estimate taken from the sum entering stage three
        mulq    = MULQ_W'(sum2_reg) * MULQ_W'(RECIP);
        qm      = SUM_W'(quo_reg) * ALPHA_SIZE;
        rem     = REM_W'(sum3_reg - qm);
        rem_fix = (rem >= REM_W'(ALPHA_SIZE)) ? rem - REM_W'(ALPHA_SIZE) : rem;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
        end
        else if (adv)
        begin
            if (issue)
            begin
                row_reg <= row_last ? '0 : row_reg + ORDER_W'(1);
            end
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < MAX_ORDER; k++)
            begin
                if (ORDER_W'(k) < job_ctl.order)
                begin
                    prod_reg[k] <= PROD_W'(key_row[k*SYM_W +: SYM_W])
                                 * PROD_W'(job_vec[k*SYM_W +: SYM_W]);
                end
                else
                begin
                    prod_reg[k] <= '0;
                end
            end
            ctl1_reg <= ctl0;
            sum2_reg <= sum_next;
            ctl2_reg <= ctl1_reg;
            sum3_reg <= sum2_reg;
            quo_reg  <= mulq[RECIP_SHIFT +: QUO_W];
            ctl3_reg <= ctl2_reg;
            char_reg <= index_to_char(rem_fix[SYM_W-1:0]);
            ctl4_reg <= ctl3_reg;
        end
    end

    assign cipher_valid  = v4_reg;
    assign out_char      = char_reg;
    assign last_of_block = ctl4_reg.last;
    assign message_done  = ctl4_reg.done;
    assign unknown_seen  = ctl4_reg.unk;

endmodule

// ===== hdl/hill_cipher_block_encrypt_top.sv =====
// hill_cipher_block_encrypt_top: configuration registers and the front, queue and back parts
// depends on hcbe_pkg, hcbe_front, hcbe_queue, hcbe_back
//
// Hill cipher encryptor over the 53-symbol alphabet A-Z, space, a-z (0xD1 reads as N).
// One character item is taken per cycle while the two-entry block queue has room; any
// other character encodes as A and sets unknown_seen on every output of its block.
// When block_size characters are held, or an item carries end_of_message, the block is
// padded with 'x' and queued. The back part emits one ciphertext item per cycle while
// cipher_ready allows, for each of the n rows of the key product, so a block of n inputs
// gives n outputs and a steady stream runs at one character per cycle; the first output
// of a block passes the product, sum, quotient and character registers. The front stalls
// only when both queue entries are taken; the whole back pipeline holds while output waits.
// block_size 0 acts as 1 and values above MAX_ORDER as MAX_ORDER; key entries are used
// as raw 6-bit values. Configuration is written through cfg_write/cfg_index/cfg_data
// (index 0 block_size, 1..7 key rows) and must only change while the block is idle.
module hill_cipher_block_encrypt_top #(
    parameter int MAX_ORDER = hcbe_pkg::MAX_ORDER_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_write,
    input  logic [hcbe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hcbe_pkg::CFG_DATA_W-1:0]   cfg_data,
    // plaintext items
    input  logic                              char_valid,
    output logic                              char_ready,
    input  logic [hcbe_pkg::CHAR_W-1:0]       char_code,
    input  logic                              end_of_message,
    // ciphertext items
    output logic                              cipher_valid,
    input  logic                              cipher_ready,
    output logic [hcbe_pkg::CHAR_W-1:0]       out_char,
    output logic                              last_of_block,
    output logic                              message_done,
    output logic                              unknown_seen
);
    import hcbe_pkg::*;

    localparam int VEC_W = MAX_ORDER * SYM_W;
    localparam int JOB_W = $bits(job_ctl_t) + VEC_W;

    logic [ORDER_W-1:0] block_size_reg;
    logic [KEY_W-1:0]   key_reg [MAX_ORDER];
    logic [ORDER_W-1:0] order;

    // block handed from front into the queue
    logic               f_valid, f_ready;
    logic [VEC_W-1:0]   f_vec;
    job_ctl_t           f_ctl;

    // block at the queue head
    logic               q_valid, q_pop;
    logic [JOB_W-1:0]   q_data;
    logic [VEC_W-1:0]   q_vec;
    job_ctl_t           q_ctl;

    // configuration registers; key rows past MAX_ORDER are never used
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= ORDER_W'(2);
            for (int r = 0; r < MAX_ORDER; r++)
            begin
                key_reg[r] <= '0;
            end
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_BLOCK_SIZE)
            begin
                block_size_reg <= cfg_data[ORDER_W-1:0];
            end
            for (int r = 0; r < MAX_ORDER; r++)
            begin
                if (cfg_index == CFG_IDX_W'(REG_KEY_ROW0) + CFG_IDX_W'(r))
                begin
                    key_reg[r] <= cfg_data[KEY_W-1:0];
                end
            end
        end
    end

    // effective order: zero acts as one, clamp to the built order
    always_comb
    begin
        priority if (block_size_reg == '0)
        begin
            order = ORDER_W'(1);
        end
        else if (block_size_reg > ORDER_W'(MAX_ORDER))
        begin
            order = ORDER_W'(MAX_ORDER);
        end
        else
        begin
            order = block_size_reg;
        end
    end

    hcbe_front #(
        .MAX_ORDER (MAX_ORDER)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .char_valid     (char_valid),
        .char_ready     (char_ready),
        .char_code      (char_code),
        .end_of_message (end_of_message),
        .order          (order),
        .job_valid      (f_valid),
        .job_ready      (f_ready),
        .job_vec        (f_vec),
        .job_ctl        (f_ctl)
    );

    hcbe_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  ({f_ctl, f_vec}),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_data)
    );

    assign q_vec = q_data[VEC_W-1:0];
    assign q_ctl = job_ctl_t'(q_data[JOB_W-1:VEC_W]);

    hcbe_back #(
        .MAX_ORDER (MAX_ORDER)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (q_valid),
        .job_pop       (q_pop),
        .job_vec       (q_vec),
        .job_ctl       (q_ctl),
        .key_rows      (key_reg),
        .cipher_valid  (cipher_valid),
        .cipher_ready  (cipher_ready),
        .out_char      (out_char),
        .last_of_block (last_of_block),
        .message_done  (message_done),
        .unknown_seen  (unknown_seen)
    );

endmodule

// ===== hdl/hcbe_checker.sv =====
// hcbe_port_checks: port-level assertions for the hill cipher block encryptor, bound to the top
// depends on hcbe_pkg and hill_cipher_block_encrypt_top
module hcbe_port_checks (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        cipher_valid,
    input logic                        cipher_ready,
    input logic [hcbe_pkg::CHAR_W-1:0] out_char,
    input logic                        last_of_block,
    input logic                        message_done,
    input logic                        unknown_seen
);
    import hcbe_pkg::*;

    logic mid_reg;
    logic unk_reg;

    // track whether an output block is partly delivered and its flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg <= 1'b0;
            unk_reg <= 1'b0;
        end
        else if (cipher_valid && cipher_ready)
        begin
            mid_reg <= !last_of_block;
            unk_reg <= unknown_seen;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cipher_valid && !cipher_ready |=> cipher_valid && $stable(out_char)
            && $stable(last_of_block) && $stable(message_done) && $stable(unknown_seen))
        else $error("output item changed while stalled");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        cipher_valid && message_done |-> last_of_block)
        else $error("message end flagged off a block end");

    a_alphabet: assert property (@(posedge clk) disable iff (!rst_n)
        cipher_valid |-> (out_char >= CH_UPPER_A && out_char <= CH_UPPER_Z)
            || (out_char >= CH_LOWER_A && out_char <= CH_LOWER_Z)
            || (out_char == CH_SPACE))
        else $error("output char outside the alphabet");

    a_unk_block: assert property (@(posedge clk) disable iff (!rst_n)
        cipher_valid && mid_reg |-> unknown_seen == unk_reg)
        else $error("unknown flag changed inside a block");

endmodule

bind hill_cipher_block_encrypt_top hcbe_port_checks u_hcbe_port_checks (.*);
